// ===== src/assert_macros.svh =====
// Assertion macros shared by the mipmap downsampler RTL.
// Depends on nothing; files that assert include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define MBD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mbd: assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define MBD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mbd: assertion failed");
`else
`define MBD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MBD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/mbd_pkg.sv =====
// Types and constants of the mipmap box downsampler.
// No dependencies; every other file but assert_macros.svh imports it.
package mbd_pkg;

  localparam int CH_W       = 8;   // one channel sample
  localparam int NUM_CH     = 4;   // channel lanes per pixel
  localparam int SUM_W      = 9;   // horizontal pair sum of one channel
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  typedef logic [NUM_CH-1:0][CH_W-1:0]  pix_t;
  typedef logic [NUM_CH-1:0][SUM_W-1:0] pair_sum_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH     = 2'd0,
    CFG_SRC_HEIGHT    = 2'd1,
    CFG_CHANNEL_COUNT = 2'd2
  } cfg_reg_t;

  // Status of the result stage between front end and output stage
  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctl_t;

endpackage

// ===== src/mbd_if.sv =====
// Handshake interfaces of the downsampler: pixel in, pixel out, register write.
// Depends on mbd_pkg.
interface mbd_in_if import mbd_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] in_ch0;
  logic [CH_W-1:0] in_ch1;
  logic [CH_W-1:0] in_ch2;
  logic [CH_W-1:0] in_ch3;
  modport source(output valid, in_ch0, in_ch1, in_ch2, in_ch3, input ready);
  modport sink(input valid, in_ch0, in_ch1, in_ch2, in_ch3, output ready);
endinterface

interface mbd_out_if import mbd_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] out_ch0;
  logic [CH_W-1:0] out_ch1;
  logic [CH_W-1:0] out_ch2;
  logic [CH_W-1:0] out_ch3;
  logic            out_last;
  modport source(output valid, out_ch0, out_ch1, out_ch2, out_ch3, out_last,
                 input ready);
  modport sink(input valid, out_ch0, out_ch1, out_ch2, out_ch3, out_last,
               output ready);
endinterface

interface mbd_cfg_if import mbd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== src/mbd_line_store.sv =====
// Line store of even-row horizontal pair sums: one write and one read port,
// read data registered. Depends on mbd_pkg.
module mbd_line_store import mbd_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  pair_sum_t     wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output pair_sum_t     rd_data
);

  pair_sum_t mem [DEPTH];
  pair_sum_t rd_data_r;

  // Write port; read data only updates on a read so it holds through stalls
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/mbd_front.sv =====
// Front end: raster position, channel masking, pair sums and line store access.
// Depends on mbd_pkg and assert_macros.svh.
`include "assert_macros.svh"
module mbd_front import mbd_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048,
  parameter int WW = $clog2(MAX_WIDTH + 1),
  parameter int HW = $clog2(MAX_HEIGHT + 1),
  parameter int AW = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  // effective configuration
  input  logic [WW-1:0]     w_eff,
  input  logic [HW-1:0]     h_eff,
  input  logic [NUM_CH-1:0] ch_en,
  // pixel input
  input  logic              in_valid,
  output logic              in_ready,
  input  pix_t              in_pix,
  // line store
  output logic              ls_wr_en,
  output logic [AW-1:0]     ls_wr_addr,
  output pair_sum_t         ls_wr_data,
  output logic              ls_rd_en,
  output logic [AW-1:0]     ls_rd_addr,
  // result stage towards the output register
  input  logic              adv,
  output stage_ctl_t        s1_ctl,
  output pair_sum_t         s1_below
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  pix_t          hold_r;
  stage_ctl_t    s1_r, s1_nxt;
  pair_sum_t     below_r;

  logic [WW-1:0] col_ext, col_inc, w_even;
  logic [HW-1:0] row_ext, row_inc, h_even;
  logic          acc, active, produce, pair_end, is_last;
  pix_t          pix;
  pair_sum_t     sums;

  assign acc      = in_valid && in_ready;
  assign in_ready = !s1_r.valid || adv;

  // Position compare and wrap
  always_comb begin
    col_ext = WW'(col_r);
    row_ext = HW'(row_r);
    col_inc = col_ext + WW'(1);
    row_inc = row_ext + HW'(1);
    w_even  = {w_eff[WW-1:1], 1'b0};
    h_even  = {h_eff[HW-1:1], 1'b0};
    active  = (col_ext < w_eff) && (row_ext < h_eff);
    if (col_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = (row_inc >= h_eff) ? '0 : RW'(row_inc);
    end else begin
      col_nxt = CW'(col_inc);
      row_nxt = row_r;
    end
  end

  // Unused channels read as zero; horizontal pair sums per lane
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      pix[c]  = ch_en[c] ? in_pix[c] : '0;
      sums[c] = {1'b0, hold_r[c]} + {1'b0, pix[c]};
    end
  end

  assign pair_end = active && col_r[0];
  assign produce  = acc && pair_end && row_r[0];
  assign is_last  = (col_ext == w_even - WW'(1)) && (row_ext == h_even - HW'(1));

  // Even rows write the line store, odd rows read the entry above.
  // An entry is written at least two transfers before it is read: no forwarding.
  assign ls_wr_en   = acc && pair_end && !row_r[0];
  assign ls_wr_addr = AW'(col_r >> 1);
  assign ls_wr_data = sums;
  assign ls_rd_en   = produce;
  assign ls_rd_addr = AW'(col_r >> 1);

  // Result stage: loaded on a producing transfer, emptied when taken
  always_comb begin
    s1_nxt = s1_r;
    if (produce) begin
      s1_nxt.valid = 1'b1;
      s1_nxt.last  = is_last;
    end else if (adv) begin
      s1_nxt.valid = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      hold_r <= '0;
      s1_r   <= '0;
    end else begin
      s1_r <= s1_nxt;
      if (acc) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
        if (active && !col_r[0]) begin
          hold_r <= pix;
        end
      end
    end
  end

  // Payload of the result stage
  always_ff @(posedge clk) begin
    if (produce) begin
      below_r <= sums;
    end
  end

  assign s1_ctl   = s1_r;
  assign s1_below = below_r;

  `MBD_ASSERT_NXT(a_s1_load, clk, rst_n, produce, s1_r.valid)
  `MBD_ASSERT_NXT(a_s1_hold, clk, rst_n, s1_r.valid && !adv,
                  s1_r.valid && $stable(s1_r.last) && $stable(below_r))
  `MBD_ASSERT_IMP(a_ls_excl, clk, rst_n, ls_rd_en, !ls_wr_en)

endmodule

// ===== src/mbd_out_stage.sv =====
// Output stage: adds the line above to the pair below, divides by four, and
// holds the result in the output register. Depends on mbd_pkg, assert_macros.svh.
`include "assert_macros.svh"
module mbd_out_stage import mbd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  stage_ctl_t s1_ctl,
  input  pair_sum_t  s1_below,
  input  pair_sum_t  above,
  output logic       adv,
  output logic       out_valid,
  input  logic       out_ready,
  output pix_t       out_pix,
  output logic       out_last
);

  logic                     out_valid_r, out_valid_nxt;
  pix_t                     out_pix_r, avg;
  logic                     out_last_r;
  logic [NUM_CH-1:0][SUM_W:0] tot;

  assign adv = !out_valid_r || out_ready;

  // Four-sample sum per lane, truncating divide by four
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      tot[c] = {1'b0, above[c]} + {1'b0, s1_below[c]};
      avg[c] = tot[c][SUM_W:2];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = s1_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload, loaded when the stage moves up
  always_ff @(posedge clk) begin
    if (adv && s1_ctl.valid) begin
      out_pix_r  <= avg;
      out_last_r <= s1_ctl.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pix   = out_pix_r;
  assign out_last  = out_last_r;

  `MBD_ASSERT_NXT(a_out_load, clk, rst_n, adv && s1_ctl.valid, out_valid_r)
  `MBD_ASSERT_NXT(a_out_drain, clk, rst_n, adv && !s1_ctl.valid, !out_valid_r)

endmodule

// ===== src/mipmap_box_downsample.sv =====
// Top level of the 2x2 box-filter mipmap downsampler: register file and wiring.
// Depends on mbd_pkg, mbd_if, mbd_line_store, mbd_front, mbd_out_stage.
//
//   channel  | dir | payload                          | transfer when
//   ---------+-----+----------------------------------+-------------------
//   in_pix   | in  | in_ch0..in_ch3                   | valid & ready
//   out_pix  | out | out_ch0..out_ch3, out_last       | valid & ready
//   cfg_wr   | in  | index (0 width, 1 height, 2 ch.) | valid & ready
//
// One source pixel per clock when not stalled. A result's bottom-right pixel
// transfer loads the result stage and the line store read; the output register
// takes it from there. Input stalls only while a result waits in the result stage
// and the output register is full and not taken. Register writes always accept.
// Reset clears position, pair hold and pipeline, sets 2 x 2, min(4, MAX_CHANNELS)
// channels; the line store is not cleared (entries are written before read).
module mipmap_box_downsample import mbd_pkg::*; #(
  parameter int MAX_WIDTH    = 2048,
  parameter int MAX_HEIGHT   = 2048,
  parameter int MAX_CHANNELS = 4
) (
  input logic       clk,
  input logic       rst_n,
  mbd_in_if.sink    in_pix,
  mbd_out_if.source out_pix,
  mbd_cfg_if.sink   cfg_wr
);

  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int DEPTH = MAX_WIDTH / 2;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NCH_RST = (MAX_CHANNELS < NUM_CH) ? MAX_CHANNELS : NUM_CH;

  logic [WW-1:0]     w_eff_r;
  logic [HW-1:0]     h_eff_r;
  logic [2:0]        nch_eff_r;
  logic [NUM_CH-1:0] ch_en;

  pix_t          in_data, out_data;
  logic          ls_wr_en, ls_rd_en, adv;
  logic [AW-1:0] ls_wr_addr, ls_rd_addr;
  pair_sum_t     ls_wr_data, ls_rd_data, s1_below;
  stage_ctl_t    s1_ctl;

  // Out-of-range values fold to the nearest legal one; channel count uses data[2:0]
  function automatic logic [WW-1:0] clamp_w(input logic [CFG_DATA_W-1:0] v);
    if (v == '0) return WW'(1);
    else if (32'(v) > MAX_WIDTH) return WW'(MAX_WIDTH);
    else return WW'(v);
  endfunction

  function automatic logic [HW-1:0] clamp_h(input logic [CFG_DATA_W-1:0] v);
    if (v == '0) return HW'(1);
    else if (32'(v) > MAX_HEIGHT) return HW'(MAX_HEIGHT);
    else return HW'(v);
  endfunction

  function automatic logic [2:0] clamp_n(input logic [2:0] v);
    if (v == '0) return 3'd1;
    else if (32'(v) > MAX_CHANNELS) return 3'(MAX_CHANNELS);
    else return v;
  endfunction

  // Register file, held in clamped form
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_eff_r   <= WW'(2);
      h_eff_r   <= HW'(2);
      nch_eff_r <= 3'(NCH_RST);
    end else if (cfg_wr.valid) begin
      case (cfg_reg_t'(cfg_wr.index))
        CFG_SRC_WIDTH:     w_eff_r   <= clamp_w(cfg_wr.data);
        CFG_SRC_HEIGHT:    h_eff_r   <= clamp_h(cfg_wr.data);
        CFG_CHANNEL_COUNT: nch_eff_r <= clamp_n(cfg_wr.data[2:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      ch_en[c] = (3'(c) < nch_eff_r);
    end
  end

  // Port unpacking
  assign in_data[0] = in_pix.in_ch0;
  assign in_data[1] = in_pix.in_ch1;
  assign in_data[2] = in_pix.in_ch2;
  assign in_data[3] = in_pix.in_ch3;

  assign out_pix.out_ch0 = out_data[0];
  assign out_pix.out_ch1 = out_data[1];
  assign out_pix.out_ch2 = out_data[2];
  assign out_pix.out_ch3 = out_data[3];

  mbd_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .WW        (WW),
    .HW        (HW),
    .AW        (AW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .w_eff     (w_eff_r),
    .h_eff     (h_eff_r),
    .ch_en     (ch_en),
    .in_valid  (in_pix.valid),
    .in_ready  (in_pix.ready),
    .in_pix    (in_data),
    .ls_wr_en  (ls_wr_en),
    .ls_wr_addr(ls_wr_addr),
    .ls_wr_data(ls_wr_data),
    .ls_rd_en  (ls_rd_en),
    .ls_rd_addr(ls_rd_addr),
    .adv       (adv),
    .s1_ctl    (s1_ctl),
    .s1_below  (s1_below)
  );

  mbd_line_store #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_line (
    .clk    (clk),
    .wr_en  (ls_wr_en),
    .wr_addr(ls_wr_addr),
    .wr_data(ls_wr_data),
    .rd_en  (ls_rd_en),
    .rd_addr(ls_rd_addr),
    .rd_data(ls_rd_data)
  );

  mbd_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_ctl   (s1_ctl),
    .s1_below (s1_below),
    .above    (ls_rd_data),
    .adv      (adv),
    .out_valid(out_pix.valid),
    .out_ready(out_pix.ready),
    .out_pix  (out_data),
    .out_last (out_pix.out_last)
  );

endmodule
